>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the voltage map.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is held low.
`define PWL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define PWL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/pwlvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlvm_pkg
// Types and constants shared by the piecewise linear voltage map modules.
// ----------------------------------------------------------------------------
package pwlvm_pkg;

    // Field widths
    localparam int X_W        = 10;   // sample and breakpoints
    localparam int Y_W        = 12;   // table values
    localparam int OUT_W      = 16;   // mapped result
    localparam int CFG_POINTS = 4;    // breakpoints held in registers
    localparam int PT_IDX_W   = 2;    // index into the breakpoint registers
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Arithmetic widths
    localparam int DX_W  = X_W + 1;   // sample minus breakpoint
    localparam int WD_W  = X_W + 1;   // segment width
    localparam int DY_W  = Y_W + 1;   // value difference
    localparam int DSR_W = X_W;       // divisor magnitude

    // Divider shape
    localparam int DIV_W              = OUT_W;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = DIV_W / DIV_BITS_PER_STAGE;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BREAK_X0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BREAK_X1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BREAK_X2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_BREAK_X3 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_Y0 = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_Y1 = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_Y2 = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_Y3 = CFG_IDX_W'(7);

    // Reset values of the table
    localparam logic [X_W-1:0] RST_BREAK_X0 = X_W'(306);
    localparam logic [X_W-1:0] RST_BREAK_X1 = X_W'(347);
    localparam logic [X_W-1:0] RST_BREAK_X2 = X_W'(376);
    localparam logic [X_W-1:0] RST_BREAK_X3 = X_W'(411);
    localparam logic [Y_W-1:0] RST_VALUE_Y0 = Y_W'(650);
    localparam logic [Y_W-1:0] RST_VALUE_Y1 = Y_W'(900);
    localparam logic [Y_W-1:0] RST_VALUE_Y2 = Y_W'(1200);
    localparam logic [Y_W-1:0] RST_VALUE_Y3 = Y_W'(1800);

    typedef enum logic [1:0] {
        MAP_ZERO,
        MAP_SAT,
        MAP_INTERP
    } t_map_kind;

    typedef struct packed {
        logic [CFG_POINTS-1:0][X_W-1:0] bx;
        logic [CFG_POINTS-1:0][Y_W-1:0] vy;
    } t_cfg;

    // Item leaving the segment/multiply stages
    typedef struct packed {
        t_map_kind                kind;
        logic [Y_W-1:0]           ya;
        logic signed [OUT_W-1:0]  prod;
        logic signed [WD_W-1:0]   wd;
    } t_seg_item;

    // Item travelling through the divider
    typedef struct packed {
        t_map_kind                kind;
        logic [Y_W-1:0]           ya;
        logic                     neg;
        logic                     bypass;
        logic [OUT_W-1:0]         pval;
        logic [DIV_W-1:0]         dvd;
        logic [DSR_W-1:0]         dsr;
        logic [DSR_W-1:0]         rem;
        logic [DIV_W-1:0]         quo;
    } t_div_item;

endpackage

>>> hdl/pwlvm_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlvm_cfg_regs
// Breakpoint and value registers with their write decoder.
// ----------------------------------------------------------------------------
module pwlvm_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pwlvm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pwlvm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output pwlvm_pkg::t_cfg                     o_cfg
);
    import pwlvm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bx[0] <= RST_BREAK_X0;
            r_cfg.bx[1] <= RST_BREAK_X1;
            r_cfg.bx[2] <= RST_BREAK_X2;
            r_cfg.bx[3] <= RST_BREAK_X3;
            r_cfg.vy[0] <= RST_VALUE_Y0;
            r_cfg.vy[1] <= RST_VALUE_Y1;
            r_cfg.vy[2] <= RST_VALUE_Y2;
            r_cfg.vy[3] <= RST_VALUE_Y3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BREAK_X0: r_cfg.bx[0] <= i_cfg_data[X_W-1:0];
                REG_BREAK_X1: r_cfg.bx[1] <= i_cfg_data[X_W-1:0];
                REG_BREAK_X2: r_cfg.bx[2] <= i_cfg_data[X_W-1:0];
                REG_BREAK_X3: r_cfg.bx[3] <= i_cfg_data[X_W-1:0];
                REG_VALUE_Y0: r_cfg.vy[0] <= i_cfg_data[Y_W-1:0];
                REG_VALUE_Y1: r_cfg.vy[1] <= i_cfg_data[Y_W-1:0];
                REG_VALUE_Y2: r_cfg.vy[2] <= i_cfg_data[Y_W-1:0];
                REG_VALUE_Y3: r_cfg.vy[3] <= i_cfg_data[Y_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/pwlvm_seg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlvm_seg
// Three stages: range check and segment search, differences, product.
// ----------------------------------------------------------------------------
module pwlvm_seg #(
    parameter int TABLE_POINTS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pwlvm_pkg::t_cfg                 i_cfg,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [pwlvm_pkg::X_W-1:0]       i_sample,
    output logic                            o_valid,
    input  logic                            i_ready,
    output pwlvm_pkg::t_seg_item            o_item
);
    import pwlvm_pkg::*;

    localparam logic [PT_IDX_W-1:0] LAST_PT = PT_IDX_W'(TABLE_POINTS - 1);
    localparam logic [PT_IDX_W-1:0] DEF_SEG = PT_IDX_W'(TABLE_POINTS - 2);

    // Stage 1 registers
    logic                   r1_v;
    logic [X_W-1:0]         r1_s;
    t_map_kind              r1_kind;
    logic [PT_IDX_W-1:0]    r1_seg;
    // Stage 2 registers
    logic                   r2_v;
    t_map_kind              r2_kind;
    logic [Y_W-1:0]         r2_ya;
    logic signed [DY_W-1:0] r2_dy;
    logic signed [DX_W-1:0] r2_dx;
    logic signed [WD_W-1:0] r2_wd;
    // Stage 3 registers
    logic                   r3_v;
    t_seg_item              r3_item;

    logic                   w_adv1, w_adv2, w_adv3;
    t_map_kind              n1_kind;
    logic [PT_IDX_W-1:0]    n1_seg;
    logic                   w_found;
    logic [PT_IDX_W-1:0]    w_seg_hi;
    logic [X_W-1:0]         w_xa, w_xb;
    logic [Y_W-1:0]         w_ya, w_yb;
    logic signed [DY_W+DX_W-1:0] w_prod;

    assign w_adv3  = !r3_v || i_ready;
    assign w_adv2  = !r2_v || w_adv3;
    assign w_adv1  = !r1_v || w_adv2;
    assign o_ready = w_adv1;

    // Range check and first segment whose upper breakpoint covers the sample
    always_comb begin
        if (i_sample < i_cfg.bx[0]) begin
            n1_kind = MAP_ZERO;
        end else if (i_sample > i_cfg.bx[LAST_PT]) begin
            n1_kind = MAP_SAT;
        end else begin
            n1_kind = MAP_INTERP;
        end
        n1_seg  = DEF_SEG;
        w_found = 1'b0;
        for (int i = 0; i < TABLE_POINTS - 2; i++) begin
            if (!w_found && (i_sample <= i_cfg.bx[PT_IDX_W'(i + 1)])) begin
                n1_seg  = PT_IDX_W'(i);
                w_found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_adv1) begin
            r1_v <= i_valid;
        end
        if (w_adv1) begin
            r1_s    <= i_sample;
            r1_kind <= n1_kind;
            r1_seg  <= n1_seg;
        end
    end

    assign w_seg_hi = r1_seg + PT_IDX_W'(1);
    assign w_xa     = i_cfg.bx[r1_seg];
    assign w_xb     = i_cfg.bx[w_seg_hi];
    assign w_ya     = (r1_kind == MAP_SAT) ? i_cfg.vy[LAST_PT] : i_cfg.vy[r1_seg];
    assign w_yb     = i_cfg.vy[w_seg_hi];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_adv2) begin
            r2_v <= r1_v;
        end
        if (w_adv2) begin
            r2_kind <= r1_kind;
            r2_ya   <= w_ya;
            r2_dy   <= {1'b0, w_yb} - {1'b0, w_ya};
            r2_dx   <= {1'b0, r1_s} - {1'b0, w_xa};
            r2_wd   <= {1'b0, w_xb} - {1'b0, w_xa};
        end
    end

    assign w_prod = r2_dy * r2_dx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_adv3) begin
            r3_v <= r2_v;
        end
        if (w_adv3) begin
            r3_item.kind <= r2_kind;
            r3_item.ya   <= r2_ya;
            r3_item.prod <= w_prod[OUT_W-1:0];
            r3_item.wd   <= r2_wd;
        end
    end

    assign o_valid = r3_v;
    assign o_item  = r3_item;

endmodule

>>> hdl/pwlvm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlvm_div
// Pipelined restoring divider on magnitudes, two quotient bits per stage.
// ----------------------------------------------------------------------------
module pwlvm_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  pwlvm_pkg::t_seg_item    i_item,
    output logic                    o_valid,
    input  logic                    i_ready,
    output pwlvm_pkg::t_div_item    o_item
);
    import pwlvm_pkg::*;

    function automatic t_div_item div_stage(input t_div_item a);
        t_div_item      b;
        logic [DSR_W:0] rs;
        b = a;
        for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
            rs    = {b.rem, b.dvd[DIV_W-1]};
            b.dvd = {b.dvd[DIV_W-2:0], 1'b0};
            if (rs >= {1'b0, b.dsr}) begin
                b.rem = DSR_W'(rs - {1'b0, b.dsr});
                b.quo = {b.quo[DIV_W-2:0], 1'b1};
            end else begin
                b.rem = rs[DSR_W-1:0];
                b.quo = {b.quo[DIV_W-2:0], 1'b0};
            end
        end
        return b;
    endfunction

    logic       r_v   [0:DIV_STAGES];
    t_div_item  r_d   [0:DIV_STAGES];
    logic       w_adv [0:DIV_STAGES];
    t_div_item  n_entry;
    logic [WD_W-1:0] w_wd_mag;

    assign w_adv[DIV_STAGES] = !r_v[DIV_STAGES] || i_ready;

    // Signs and magnitudes of dividend and divisor
    always_comb begin
        w_wd_mag       = i_item.wd[WD_W-1] ? (~i_item.wd + 1'b1) : i_item.wd;
        n_entry.kind   = i_item.kind;
        n_entry.ya     = i_item.ya;
        n_entry.neg    = i_item.prod[OUT_W-1] ^ i_item.wd[WD_W-1];
        n_entry.bypass = (i_item.wd == '0);
        n_entry.pval   = i_item.prod;
        n_entry.dvd    = i_item.prod[OUT_W-1] ? (~i_item.prod + 1'b1) : i_item.prod;
        n_entry.dsr    = w_wd_mag[DSR_W-1:0];
        n_entry.rem    = '0;
        n_entry.quo    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_adv[0]) begin
            r_v[0] <= i_valid;
        end
        if (w_adv[0]) begin
            r_d[0] <= n_entry;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_adv
        assign w_adv[k] = !r_v[k] || w_adv[k+1];
    end

    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_adv[k]) begin
                r_v[k] <= r_v[k-1];
            end
            if (w_adv[k]) begin
                r_d[k] <= div_stage(r_d[k-1]);
            end
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_v[DIV_STAGES];
    assign o_item  = r_d[DIV_STAGES];

endmodule

>>> hdl/piecewise_linear_voltage_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_voltage_map
// Maps an averaged ignition converter sample through a breakpoint table by
// linear interpolation between neighbouring points.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                    Payload
//  -------  ---------  ---------------------------  ------------------------
//  in       input      i_in_valid / o_in_ready      i_sample (10 bit)
//  out      output     o_out_valid / i_out_ready    o_mapped_value (16 bit s)
//  cfg      input      i_cfg_we                     i_cfg_index, i_cfg_data
//
//  One item is accepted per cycle while o_in_ready is high; the pipeline is made
//  of the three table stages, the divider entry stage, the eight divider
//  stages (two quotient bits each) and the output register.
//  Reset is synchronous and active low; it clears the valid bits of every
//  stage and loads the default table.
//  Each stage holds its item while the stage after it is full, so a stall at
//  the output fills the empty stages first and then holds o_in_ready low.
//
// A sample below the first breakpoint gives zero, a sample above the last one
// gives the last table value. Otherwise the first segment whose upper
// breakpoint is at least the sample is chosen and the result is
// ya + wrap16(wrap16((yb - ya) * (x - xa)) / (xb - xa)), where the division
// truncates toward zero and is skipped for a segment of zero width. All sums
// wrap to sixteen bits, so -32768 divided by -1 comes out as -32768.
//
// The table registers are expected to change only while no item is in flight.
// ----------------------------------------------------------------------------
module piecewise_linear_voltage_map #(
    parameter int TABLE_POINTS = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [pwlvm_pkg::X_W-1:0]            i_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [pwlvm_pkg::OUT_W-1:0]   o_mapped_value,
    input  logic                                 i_cfg_we,
    input  logic [pwlvm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pwlvm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pwlvm_pkg::*;

    t_cfg               w_cfg;
    logic               w_seg_valid, w_seg_ready;
    t_seg_item          w_seg_item;
    logic               w_div_valid, w_div_ready;
    t_div_item          w_div_item;

    logic               r_out_valid;
    logic [OUT_W-1:0]   r_mapped;
    logic [OUT_W-1:0]   n_mapped;
    logic [OUT_W-1:0]   w_quo_signed;
    logic [OUT_W-1:0]   w_quo_final;

    pwlvm_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Range check, segment choice, differences and the wrapped product
    pwlvm_seg #(
        .TABLE_POINTS (TABLE_POINTS)
    ) u_seg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_sample (i_sample),
        .o_valid  (w_seg_valid),
        .i_ready  (w_seg_ready),
        .o_item   (w_seg_item)
    );

    // Division of the product by the segment width
    pwlvm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_seg_valid),
        .o_ready (w_seg_ready),
        .i_item  (w_seg_item),
        .o_valid (w_div_valid),
        .i_ready (w_div_ready),
        .o_item  (w_div_item)
    );

    // Output register: sign of the quotient, offset by ya, range cases.
    assign w_div_ready  = !r_out_valid || i_out_ready;
    assign w_quo_signed = w_div_item.neg ? (~w_div_item.quo + 1'b1) : w_div_item.quo;
    assign w_quo_final  = w_div_item.bypass ? w_div_item.pval : w_quo_signed;

    always_comb begin
        case (w_div_item.kind)
            MAP_ZERO:   n_mapped = '0;
            MAP_SAT:    n_mapped = {{(OUT_W-Y_W){1'b0}}, w_div_item.ya};
            MAP_INTERP: n_mapped = w_quo_final + {{(OUT_W-Y_W){1'b0}}, w_div_item.ya};
            default:    n_mapped = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_div_ready) begin
            r_out_valid <= w_div_valid;
        end
        if (w_div_ready) begin
            r_mapped <= n_mapped;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_mapped_value = r_mapped;

endmodule

>>> hdl/pwlvm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlvm_checker
// Port level assertions for the voltage map, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pwlvm_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 o_in_ready,
    input  logic [pwlvm_pkg::X_W-1:0]            i_sample,
    input  logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    input  logic signed [pwlvm_pkg::OUT_W-1:0]   o_mapped_value
);

    // A stalled result stays offered.
    `PWL_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped while stalled")

    // A stalled result keeps its value.
    `PWL_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_mapped_value), "result changed while stalled")

    // A waiting sample stays offered with the same value.
    `PWL_ASSERT(a_in_hold, i_clk, i_rst_n, i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_sample), "sample changed while waiting")

    // With the output free to move the whole pipeline moves and the input is ready.
    `PWL_ASSERT(a_in_ready, i_clk, i_rst_n, !o_out_valid || i_out_ready |-> o_in_ready, "input blocked with output free")

    // Reset empties the pipeline.
    `PWL_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result offered after reset")

endmodule

bind piecewise_linear_voltage_map pwlvm_checker u_pwlvm_checker (.*);
